// ----- rtl/modular_exponentiation_unit_assert.svh -----
// Assertion macros shared by the modular exponentiation unit.
`ifndef MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`define MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH

// The condition must hold on every rising clock edge while out of reset.
`define MEU_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define MEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mexp_pkg.sv -----
// Shared types, constants and microcode program of the modular exponentiation unit.
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int MOD_WIDTH      = 16;
    localparam int EXP_WIDTH      = 31;
    localparam int BASE_WIDTH     = 31;
    localparam int PROD_WIDTH     = 2 * MOD_WIDTH;
    localparam int CNT_WIDTH      = $clog2(PROD_WIDTH);
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int PC_WIDTH       = 4;

    localparam logic [CNT_WIDTH-1:0]     CNT_LAST     = CNT_WIDTH'(PROD_WIDTH - 1);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MODULUS  = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_EXPONENT = CFG_IDX_WIDTH'(1);

    typedef logic [PC_WIDTH-1:0] t_pc;

    // Program addresses.
    localparam t_pc PC_IDLE     = PC_WIDTH'(0);
    localparam t_pc PC_RED_BASE = PC_WIDTH'(1);
    localparam t_pc PC_WR_BASE  = PC_WIDTH'(2);
    localparam t_pc PC_TEST_BIT = PC_WIDTH'(3);
    localparam t_pc PC_MUL_ACC  = PC_WIDTH'(4);
    localparam t_pc PC_RED_ACC  = PC_WIDTH'(5);
    localparam t_pc PC_WR_ACC   = PC_WIDTH'(6);
    localparam t_pc PC_SHIFT    = PC_WIDTH'(7);
    localparam t_pc PC_RED_SQ   = PC_WIDTH'(8);
    localparam t_pc PC_WR_SQ    = PC_WIDTH'(9);
    localparam t_pc PC_EMIT     = PC_WIDTH'(10);
    localparam t_pc PC_RETURN   = PC_WIDTH'(11);

    typedef enum logic [1:0] {
        LD_NONE,
        LD_BASE,
        LD_ACC_MUL,
        LD_SQ_MUL
    } t_load;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_ACC,
        WR_SQ
    } t_write;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_RED_BUSY,
        COND_EXP_ZERO,
        COND_BIT0_CLR,
        COND_EXP_LAST,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_load  load;
        logic   red;
        t_write wr;
        logic   exp_shift;
        logic   accept;
        logic   emit;
        logic   hold;
        t_cond  cond;
        t_pc    target;
    } t_ctrl;

    typedef struct packed {
        logic red_busy;
        logic exp_zero;
        logic exp_last;
        logic exp_bit0;
        logic out_busy;
    } t_status;

    localparam t_ctrl CTRL_NOP = '{
        load: LD_NONE, red: 1'b0, wr: WR_NONE, exp_shift: 1'b0, accept: 1'b0,
        emit: 1'b0, hold: 1'b0, cond: COND_NEVER, target: PC_IDLE
    };

    // Microcode store. A jump goes to target when cond holds, otherwise to the
    // next step. With hold set, a taken jump also suppresses the step's actions other than accept.
    function automatic t_ctrl mexp_ucode(input t_pc pc);
        t_ctrl w;
        w = CTRL_NOP;
        unique case (pc)
            PC_IDLE: begin
                w.load   = LD_BASE;
                w.accept = 1'b1;
                w.hold   = 1'b1;
                w.cond   = COND_NO_INPUT;
                w.target = PC_IDLE;
            end
            PC_RED_BASE: begin
                w.red    = 1'b1;
                w.cond   = COND_RED_BUSY;
                w.target = PC_RED_BASE;
            end
            PC_WR_BASE: begin
                w.wr     = WR_SQ;
                w.cond   = COND_EXP_ZERO;
                w.target = PC_EMIT;
            end
            PC_TEST_BIT: begin
                w.cond   = COND_BIT0_CLR;
                w.target = PC_SHIFT;
            end
            PC_MUL_ACC: begin
                w.load = LD_ACC_MUL;
            end
            PC_RED_ACC: begin
                w.red    = 1'b1;
                w.cond   = COND_RED_BUSY;
                w.target = PC_RED_ACC;
            end
            PC_WR_ACC: begin
                w.wr = WR_ACC;
            end
            PC_SHIFT: begin
                w.load      = LD_SQ_MUL;
                w.exp_shift = 1'b1;
                w.cond      = COND_EXP_LAST;
                w.target    = PC_EMIT;
            end
            PC_RED_SQ: begin
                w.red    = 1'b1;
                w.cond   = COND_RED_BUSY;
                w.target = PC_RED_SQ;
            end
            PC_WR_SQ: begin
                w.wr     = WR_SQ;
                w.cond   = COND_ALWAYS;
                w.target = PC_TEST_BIT;
            end
            PC_EMIT: begin
                w.emit   = 1'b1;
                w.hold   = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = PC_EMIT;
            end
            PC_RETURN: begin
                w.cond   = COND_ALWAYS;
                w.target = PC_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/modular_exponentiation_unit.sv -----
// Top level of the modular exponentiation unit: key registers and sequencer/datapath.
//
// Computes base^exponent mod modulus with right-to-left square-and-multiply.
// Configuration: write index 0 (modulus, low 16 data bits) or index 1
// (exponent, low 31 bits) on the cfg channel; ready is always high and a
// write to any other index is dropped. Write only while the unit is idle.
// Input: a base value is taken when i_in_valid is high and o_in_stall low.
// Output: one result per input, held on o_power_result while o_out_valid is
// high and i_out_stall is high; it leaves at an edge with i_out_stall low.
// Operation: all modular reductions share one bit-serial reducer; the reductions
// of the accumulator and square products each follow a registered 16x16
// product, while the base is reduced directly. Items are processed one at a
// time: the next base is taken only after the result has been emitted.
// A stalled result blocks completion of the following item only at its end.
// Reset (synchronous, active low) sets modulus and exponent to 1 and empties
// the output register.
`timescale 1ns / 1ps

module modular_exponentiation_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [mexp_pkg::CFG_IDX_WIDTH-1:0]      i_cfg_index,
    input  logic [mexp_pkg::CFG_DATA_WIDTH-1:0]     i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [mexp_pkg::BASE_WIDTH-1:0]         i_base_value,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [mexp_pkg::MOD_WIDTH-1:0]          o_power_result
);
    import mexp_pkg::*;

    logic [MOD_WIDTH-1:0] r_modulus;
    logic [EXP_WIDTH-1:0] r_exponent;
    t_ctrl                ctrl;
    t_status              status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= MOD_WIDTH'(1);
            r_exponent <= EXP_WIDTH'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODULUS:  r_modulus  <= i_cfg_data[MOD_WIDTH-1:0];
                CFG_EXPONENT: r_exponent <= i_cfg_data[EXP_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    mexp_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_ctrl     (ctrl),
        .o_in_stall (o_in_stall)
    );

    mexp_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_base_value   (i_base_value),
        .i_modulus      (r_modulus),
        .i_exponent     (r_exponent),
        .i_out_stall    (i_out_stall),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_power_result (o_power_result)
    );

endmodule

// ----- rtl/mexp_sequencer.sv -----
// Microcode sequencer: step counter, control store lookup and jump logic.
`timescale 1ns / 1ps
`include "modular_exponentiation_unit_assert.svh"

module mexp_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  mexp_pkg::t_status i_status,
    output mexp_pkg::t_ctrl  o_ctrl,
    output logic             o_in_stall
);
    import mexp_pkg::*;

    t_pc   r_pc;
    t_pc   n_pc;
    t_ctrl word;
    logic  take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        word = mexp_ucode(r_pc);
        unique case (word.cond)
            COND_NEVER:    take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_INPUT: take = !i_in_valid;
            COND_RED_BUSY: take = i_status.red_busy;
            COND_EXP_ZERO: take = i_status.exp_zero;
            COND_BIT0_CLR: take = !i_status.exp_bit0;
            COND_EXP_LAST: take = i_status.exp_last;
            COND_OUT_BUSY: take = i_status.out_busy;
        endcase
        n_pc   = take ? word.target : r_pc + PC_WIDTH'(1);
        o_ctrl = word;
        if (word.hold && take) begin
            o_ctrl.load      = LD_NONE;
            o_ctrl.red       = 1'b0;
            o_ctrl.wr        = WR_NONE;
            o_ctrl.exp_shift = 1'b0;
            o_ctrl.emit      = 1'b0;
        end
    end

    assign o_in_stall = !word.accept;

    `MEU_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        r_pc == PC_RED_BASE, "accepted transaction did not start the base reduction")
    `MEU_ASSERT_ALWAYS(a_pc_in_program, i_clk, i_rst_n, r_pc <= PC_RETURN,
        "step counter left the program")

endmodule

// ----- rtl/mexp_datapath.sv -----
// Datapath: operand registers, 16x16 multiplier, bit-serial reducer and output register.
`timescale 1ns / 1ps
`include "modular_exponentiation_unit_assert.svh"

module mexp_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mexp_pkg::t_ctrl                      i_ctrl,
    input  logic [mexp_pkg::BASE_WIDTH-1:0]      i_base_value,
    input  logic [mexp_pkg::MOD_WIDTH-1:0]       i_modulus,
    input  logic [mexp_pkg::EXP_WIDTH-1:0]       i_exponent,
    input  logic                                 i_out_stall,
    output mexp_pkg::t_status                    o_status,
    output logic                                 o_out_valid,
    output logic [mexp_pkg::MOD_WIDTH-1:0]       o_power_result
);
    import mexp_pkg::*;

    logic [PROD_WIDTH-1:0] r_x;
    logic [MOD_WIDTH-1:0]  r_rem;
    logic [MOD_WIDTH-1:0]  r_mod;
    logic [CNT_WIDTH-1:0]  r_bitcnt;
    logic [MOD_WIDTH-1:0]  r_acc;
    logic [MOD_WIDTH-1:0]  r_sq;
    logic [EXP_WIDTH-1:0]  r_exp;
    logic [MOD_WIDTH-1:0]  r_result;
    logic                  r_out_valid;

    logic [MOD_WIDTH:0]    trial;
    logic [MOD_WIDTH:0]    diff;
    logic [MOD_WIDTH-1:0]  red_rem;
    logic [MOD_WIDTH-1:0]  mod_eff;
    logic                  out_busy;

    // Restoring reduction: shift in one dividend bit, subtract the modulus if it fits.
    // The remainder stays below the modulus, so the trial value stays below twice it.
    assign trial   = {r_rem, r_x[PROD_WIDTH-1]};
    assign diff    = trial - {1'b0, r_mod};
    assign red_rem = diff[MOD_WIDTH] ? trial[MOD_WIDTH-1:0] : diff[MOD_WIDTH-1:0];

    // A zero modulus behaves like a modulus of one.
    assign mod_eff  = (i_modulus == '0) ? MOD_WIDTH'(1) : i_modulus;
    assign out_busy = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_mod       <= MOD_WIDTH'(1);
            r_bitcnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.load != LD_NONE) begin
                r_rem    <= '0;
                r_bitcnt <= '0;
            end else if (i_ctrl.red) begin
                r_rem    <= red_rem;
                r_bitcnt <= r_bitcnt + CNT_WIDTH'(1);
            end
            if (i_ctrl.load == LD_BASE) begin
                r_mod <= mod_eff;
            end
            if (i_ctrl.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.load)
            LD_NONE: begin
                if (i_ctrl.red) begin
                    r_x <= {r_x[PROD_WIDTH-2:0], 1'b0};
                end
            end
            LD_BASE: begin
                r_x   <= PROD_WIDTH'(i_base_value);
                r_acc <= MOD_WIDTH'(1);
                r_exp <= i_exponent;
            end
            LD_ACC_MUL: r_x <= PROD_WIDTH'(r_acc) * PROD_WIDTH'(r_sq);
            LD_SQ_MUL:  r_x <= PROD_WIDTH'(r_sq) * PROD_WIDTH'(r_sq);
            default:    r_x <= r_x;
        endcase
        unique case (i_ctrl.wr)
            WR_ACC:  r_acc <= r_rem;
            WR_SQ:   r_sq  <= r_rem;
            default: ;
        endcase
        if (i_ctrl.exp_shift) begin
            r_exp <= r_exp >> 1;
        end
        if (i_ctrl.emit) begin
            r_result <= r_acc;
        end
    end

    assign o_status.red_busy = r_bitcnt != CNT_LAST;
    assign o_status.exp_zero = r_exp == '0;
    assign o_status.exp_last = r_exp[EXP_WIDTH-1:1] == '0;
    assign o_status.exp_bit0 = r_exp[0];
    assign o_status.out_busy = out_busy;

    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_result;

    `MEU_ASSERT_ALWAYS(a_rem_below_mod, i_clk, i_rst_n, r_rem < r_mod,
        "partial remainder reached the modulus")
    `MEU_ASSERT_ALWAYS(a_mod_nonzero, i_clk, i_rst_n, r_mod != '0,
        "working modulus is zero")
    `MEU_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, i_ctrl.emit,
        r_out_valid, "emitted result did not raise output valid")

endmodule
